>>> sv/ouart_pkg.sv
// Package for the oversampled UART transceiver.
// Holds frame constants, action codes, step/result structs and the vote helper.
// No dependencies.
`default_nettype none

package ouart_pkg;

   // oversampling set-up
   localparam int SAMPLES_PER_BIT     = 8;
   localparam int START_CHECK_SAMPLES = 3;

   // frame layout
   localparam int DATA_BITS  = 8;
   localparam int FRAME_BITS = DATA_BITS + 2;

   localparam int TICK_W    = 6;
   localparam int BIT_IDX_W = 4;

   typedef logic [DATA_BITS-1:0] byte_type;
   typedef logic [TICK_W-1:0]    tick_type;
   typedef logic [BIT_IDX_W-1:0] bit_idx_type;

   localparam logic LEVEL_LOW   = 1'b0;
   localparam logic LEVEL_HIGH  = 1'b1;
   localparam logic START_LEVEL = LEVEL_LOW;

   // action codes
   localparam logic ACT_TICK = 1'b0;
   localparam logic ACT_SEND = 1'b1;

   localparam tick_type    SPB_LAST      = TICK_W'(SAMPLES_PER_BIT - 1);
   localparam tick_type    START_CHECK   = TICK_W'(START_CHECK_SAMPLES);
   localparam bit_idx_type FIRST_DATA    = BIT_IDX_W'(1);
   localparam bit_idx_type STOP_BIT_IDX  = BIT_IDX_W'(FRAME_BITS - 1);
   localparam bit_idx_type FRAME_END     = BIT_IDX_W'(FRAME_BITS);
   localparam bit_idx_type RX_DATA_BASE  = BIT_IDX_W'(2);

   // sample store: one entry per sample slot of a bit
   localparam int MID_INDEX   = (SAMPLES_PER_BIT - 1) / 2;
   localparam int STORE_DEPTH = SAMPLES_PER_BIT;
   localparam int STORE_IDX_W = $clog2(STORE_DEPTH);
   localparam logic [TICK_W:0] STORE_LIMIT = (TICK_W + 1)'(STORE_DEPTH);

   localparam int DATA_IDX_W = $clog2(DATA_BITS);

   typedef struct packed {
      logic     tick;
      logic     send;
      byte_type tx_byte;
   } tx_step_type;

   typedef struct packed {
      logic tx_line;
      logic send_accepted;
      logic tx_complete;
      logic tx_idle;
   } tx_result_type;

   typedef struct packed {
      logic     rx_valid;
      byte_type rx_byte;
   } rx_result_type;

   typedef struct packed {
      logic     action;
      logic     rx_sample;
      byte_type tx_byte;
   } req_payload_type;

   typedef struct packed {
      tx_result_type tx;
      rx_result_type rx;
   } rsp_payload_type;

   function automatic logic maj3(input logic a, input logic b, input logic c);
      return (a & b) | (b & c) | (a & c);
   endfunction

endpackage

`default_nettype wire

>>> sv/ouart_req_if.sv
// Request channel of the UART transceiver: sample tick or send request.
// Depends on ouart_pkg for the byte type.
`default_nettype none

interface ouart_req_if;
   logic                 valid;
   logic                 ready;
   logic                 action;
   logic                 rx_sample;
   ouart_pkg::byte_type  tx_byte;

   modport source (output valid, output action, output rx_sample, output tx_byte,
                   input ready);
   modport sink   (input valid, input action, input rx_sample, input tx_byte,
                   output ready);
endinterface

`default_nettype wire

>>> sv/ouart_rsp_if.sv
// Response channel of the UART transceiver: line level and status per step.
// Depends on ouart_pkg for the byte type.
`default_nettype none

interface ouart_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 tx_line;
   logic                 send_accepted;
   logic                 tx_complete;
   logic                 tx_idle;
   logic                 rx_valid;
   ouart_pkg::byte_type  rx_byte;

   modport source (output valid, output tx_line, output send_accepted,
                   output tx_complete, output tx_idle, output rx_valid,
                   output rx_byte, input ready);
   modport sink   (input valid, input tx_line, input send_accepted,
                   input tx_complete, input tx_idle, input rx_valid,
                   input rx_byte, output ready);
endinterface

`default_nettype wire

>>> sv/ouart_tx.sv
// Transmit side: 8N1 framer holding each data and stop bit for SAMPLES_PER_BIT ticks.
// Depends on ouart_pkg. State advances only on a step strobe from the top.
`default_nettype none

module ouart_tx (
   input  wire                       clock,
   input  wire                       reset,
   input  ouart_pkg::tx_step_type    step,
   output ouart_pkg::tx_result_type  result
);
   import ouart_pkg::*;

   tick_type    tx_tick_count_ff, tx_tick_count_in;
   bit_idx_type tx_bit_index_ff,  tx_bit_index_in;
   logic        tx_busy_ff,       tx_busy_in;
   byte_type    tx_hold_ff,       tx_hold_in;
   logic        tx_level_ff,      tx_level_in;
   logic        accepted;
   logic        complete;
   bit_idx_type bit_step;

   assign bit_step = tx_bit_index_ff + FIRST_DATA;

   always_comb begin
      tx_tick_count_in = tx_tick_count_ff;
      tx_bit_index_in  = tx_bit_index_ff;
      tx_busy_in       = tx_busy_ff;
      tx_hold_in       = tx_hold_ff;
      tx_level_in      = tx_level_ff;
      accepted         = 1'b0;
      complete         = 1'b0;
      if (step.send) begin
         if (!tx_busy_ff) begin
            tx_bit_index_in  = '0;
            tx_tick_count_in = '0;
            tx_hold_in       = step.tx_byte;
            tx_busy_in       = 1'b1;
            accepted         = 1'b1;
         end
      end else if (step.tick && tx_busy_ff) begin
         if (tx_tick_count_ff < SPB_LAST) begin
            // start bit goes low on the first tick after the send
            if (tx_bit_index_ff == '0) begin
               tx_level_in = START_LEVEL;
            end
            tx_tick_count_in = tx_tick_count_ff + tick_type'(1);
         end else begin
            tx_bit_index_in  = bit_step;
            tx_tick_count_in = '0;
            if (bit_step >= FIRST_DATA && bit_step < STOP_BIT_IDX) begin
               tx_level_in = tx_hold_ff[DATA_IDX_W'(bit_step - FIRST_DATA)];
            end else if (bit_step == STOP_BIT_IDX) begin
               tx_level_in = LEVEL_HIGH;
            end else if (bit_step == FRAME_END) begin
               complete        = 1'b1;
               tx_busy_in      = 1'b0;
               tx_bit_index_in = '0;
            end else begin
               // stray index: drop the frame without a completion pulse
               tx_busy_in      = 1'b0;
               tx_bit_index_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_tick_count_ff <= '0;
         tx_bit_index_ff  <= '0;
         tx_busy_ff       <= 1'b0;
         tx_hold_ff       <= '0;
         tx_level_ff      <= LEVEL_HIGH;
      end else begin
         tx_tick_count_ff <= tx_tick_count_in;
         tx_bit_index_ff  <= tx_bit_index_in;
         tx_busy_ff       <= tx_busy_in;
         tx_hold_ff       <= tx_hold_in;
         tx_level_ff      <= tx_level_in;
      end
   end

   assign result.tx_line       = tx_level_in;
   assign result.send_accepted = accepted;
   assign result.tx_complete   = complete;
   assign result.tx_idle       = !tx_busy_in;

   a_idle_line_high: assert property (@(posedge clock) disable iff (reset)
      !tx_busy_ff |-> tx_level_ff == LEVEL_HIGH)
      else $error("tx line not high while idle");

   a_bit_index_range: assert property (@(posedge clock) disable iff (reset)
      tx_bit_index_ff < FRAME_END)
      else $error("tx bit index out of frame");

   a_complete_frees: assert property (@(posedge clock) disable iff (reset)
      complete |=> !tx_busy_ff && tx_bit_index_ff == '0)
      else $error("tx still busy after completion");

endmodule

`default_nettype wire

>>> sv/ouart_rx.sv
// Receive side: start qualification and 3-sample majority per bit.
// Depends on ouart_pkg. Sample store is a small register file read at fixed slots.
`default_nettype none

module ouart_rx (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       sample_en,
   input  wire                       rx_sample,
   output ouart_pkg::rx_result_type  result
);
   import ouart_pkg::*;

   tick_type    rx_tick_count_ff, rx_tick_count_in;
   bit_idx_type rx_bit_index_ff,  rx_bit_index_in;
   logic        rx_in_frame_ff,   rx_in_frame_in;
   byte_type    rx_assembled_ff,  rx_assembled_in;
   logic        sample_store_ff [STORE_DEPTH];

   logic        keep;
   logic        store_we;
   logic        good;
   logic        start_vote;
   logic        mid_vote;
   bit_idx_type bit_step;

   assign start_vote = maj3(sample_store_ff[0], sample_store_ff[1], sample_store_ff[2]);
   assign mid_vote   = maj3(sample_store_ff[MID_INDEX-1], sample_store_ff[MID_INDEX],
                            sample_store_ff[MID_INDEX+1]);
   assign bit_step   = rx_bit_index_ff + FIRST_DATA;

   always_comb begin
      rx_tick_count_in = rx_tick_count_ff;
      rx_bit_index_in  = rx_bit_index_ff;
      rx_in_frame_in   = rx_in_frame_ff;
      rx_assembled_in  = rx_assembled_ff;
      keep             = 1'b0;
      good             = 1'b0;
      if (sample_en) begin
         if (!rx_in_frame_ff) begin
            if (rx_tick_count_ff == '0) begin
               keep = (rx_sample == LEVEL_LOW);
            end else if (rx_tick_count_ff < START_CHECK) begin
               keep = 1'b1;
            end else if (rx_tick_count_ff == START_CHECK) begin
               // early start check over the first three samples
               if (start_vote == START_LEVEL) begin
                  keep = 1'b1;
               end else begin
                  rx_tick_count_in = '0;
               end
            end else if (rx_tick_count_ff < SPB_LAST) begin
               keep = 1'b1;
            end else if (rx_tick_count_ff == SPB_LAST) begin
               if (mid_vote == START_LEVEL) begin
                  rx_in_frame_in  = 1'b1;
                  rx_bit_index_in = FIRST_DATA;
                  rx_assembled_in = '0;
               end
               rx_tick_count_in = '0;
            end else begin
               rx_tick_count_in = '0;
            end
         end else if (rx_tick_count_ff < SPB_LAST) begin
            keep = 1'b1;
         end else begin
            rx_tick_count_in = '0;
            rx_bit_index_in  = bit_step;
            if (bit_step < FRAME_END) begin
               rx_assembled_in[DATA_IDX_W'(bit_step - RX_DATA_BASE)] = mid_vote;
            end else begin
               // stop bit: deliver only on a high decision
               good            = (mid_vote == LEVEL_HIGH);
               rx_bit_index_in = '0;
               rx_in_frame_in  = 1'b0;
            end
         end
         if (keep) begin
            rx_tick_count_in = rx_tick_count_ff + tick_type'(1);
         end
      end
   end

   // slots past the store are never voted on
   assign store_we = keep && ({1'b0, rx_tick_count_ff} < STORE_LIMIT);

   always_ff @(posedge clock) begin
      if (store_we) begin
         sample_store_ff[rx_tick_count_ff[STORE_IDX_W-1:0]] <= rx_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_tick_count_ff <= '0;
         rx_bit_index_ff  <= '0;
         rx_in_frame_ff   <= 1'b0;
         rx_assembled_ff  <= '0;
      end else begin
         rx_tick_count_ff <= rx_tick_count_in;
         rx_bit_index_ff  <= rx_bit_index_in;
         rx_in_frame_ff   <= rx_in_frame_in;
         rx_assembled_ff  <= rx_assembled_in;
      end
   end

   assign result.rx_valid = good;
   assign result.rx_byte  = rx_assembled_in;

   a_frame_index: assert property (@(posedge clock) disable iff (reset)
      rx_in_frame_ff |-> rx_bit_index_ff >= FIRST_DATA && rx_bit_index_ff <= STOP_BIT_IDX)
      else $error("rx bit index out of frame");

   a_hunt_index: assert property (@(posedge clock) disable iff (reset)
      !rx_in_frame_ff |-> rx_bit_index_ff == '0)
      else $error("rx bit index set while hunting");

   a_valid_ends_frame: assert property (@(posedge clock) disable iff (reset)
      good |=> !rx_in_frame_ff && rx_tick_count_ff == '0)
      else $error("rx frame not closed after delivery");

endmodule

`default_nettype wire

>>> sv/oversampled_uart_transceiver.sv
// Top level of the oversampled 8N1 UART transceiver.
// Depends on ouart_pkg, ouart_req_if, ouart_rsp_if, ouart_tx and ouart_rx.
//
//   Channel    Dir   Moves                                   Transfer when
//   req_chan   in    tick (rx_sample) or send (tx_byte)      valid & ready
//   rsp_chan   out   tx line/status, rx valid/byte           valid & ready
//
// One request in, one response out, via the input register, then the state
// update and result register. A transfer can occur each cycle unless stalled.
// Reset is synchronous, active high; the line idles high, both sides idle.
// A stalled response holds; the input register still takes one more request.
`default_nettype none

module oversampled_uart_transceiver (
   input  wire        clock,
   input  wire        reset,
   ouart_req_if.sink   req_chan,
   ouart_rsp_if.source rsp_chan
);
   import ouart_pkg::*;

   logic            stage_valid_ff, stage_valid_in;
   req_payload_type stage_ff;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff;

   logic            req_fire;
   logic            out_load;
   logic            step_go;
   logic            tick_go;
   tx_step_type     tx_step;
   tx_result_type   tx_result;
   rx_result_type   rx_result;

   assign out_load       = !out_valid_ff || rsp_chan.ready;
   assign step_go        = stage_valid_ff && out_load;
   assign req_chan.ready = !stage_valid_ff || step_go;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign tick_go         = step_go && (stage_ff.action == ACT_TICK);
   assign tx_step.tick    = tick_go;
   assign tx_step.send    = step_go && (stage_ff.action == ACT_SEND);
   assign tx_step.tx_byte = stage_ff.tx_byte;

   ouart_tx u_tx (
      .clock  (clock),
      .reset  (reset),
      .step   (tx_step),
      .result (tx_result)
   );

   ouart_rx u_rx (
      .clock     (clock),
      .reset     (reset),
      .sample_en (tick_go),
      .rx_sample (stage_ff.rx_sample),
      .result    (rx_result)
   );

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_fire) begin
         stage_valid_in = 1'b1;
      end else if (step_go) begin
         stage_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step_go) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_ff.action    <= req_chan.action;
         stage_ff.rx_sample <= req_chan.rx_sample;
         stage_ff.tx_byte   <= req_chan.tx_byte;
      end
      if (step_go) begin
         out_ff.tx <= tx_result;
         out_ff.rx <= rx_result;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.tx_line       = out_ff.tx.tx_line;
   assign rsp_chan.send_accepted = out_ff.tx.send_accepted;
   assign rsp_chan.tx_complete   = out_ff.tx.tx_complete;
   assign rsp_chan.tx_idle       = out_ff.tx.tx_idle;
   assign rsp_chan.rx_valid      = out_ff.rx.rx_valid;
   assign rsp_chan.rx_byte       = out_ff.rx.rx_byte;

   a_step_fills_output: assert property (@(posedge clock) disable iff (reset)
      step_go |=> out_valid_ff)
      else $error("step taken but no response registered");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |-> !step_go)
      else $error("response overwritten while stalled");

   a_send_only_on_send: assert property (@(posedge clock) disable iff (reset)
      step_go && stage_ff.action == ACT_TICK |-> !tx_result.send_accepted)
      else $error("send accepted on a sample tick");

endmodule

`default_nettype wire
